// ===== src/aebs_pkg.sv =====
// ----------------------------------------------------------------------------
// aebs_pkg
// Shared types and constants for the ASK envelope bit slicer.
// ----------------------------------------------------------------------------
package aebs_pkg;

   localparam int HISTORY_BITS  = 16;
   localparam int ENV_W         = 18;
   localparam int PERIOD_W      = 10;
   localparam int PHASE_W       = PERIOD_W + 1;
   localparam int VOTE_W        = 10;
   localparam int RECENT_W      = 16;
   localparam int COUNT_W       = 32;
   localparam int TOTAL_W       = 48;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 18;

   localparam logic [ENV_W-1:0]    THRESHOLD_RESET = ENV_W'(6000);
   localparam logic [PERIOD_W-1:0] SPB_RESET       = PERIOD_W'(180);
   localparam logic [PERIOD_W-1:0] SPE_RESET       = PERIOD_W'(40);
   localparam logic [VOTE_W-1:0]   VOTE_MAX        = '1;
   localparam logic [7:0]          PATTERN_55      = 8'h55;
   localparam logic [7:0]          PATTERN_AA      = 8'hAA;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VOTE_THRESHOLD       = 2'd0,
      CSR_SAMPLES_PER_BIT      = 2'd1,
      CSR_SAMPLES_PER_ENVELOPE = 2'd2,
      CSR_UNUSED               = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ENV_W-1:0]    vote_threshold;
      logic [PERIOD_W-1:0] samples_per_bit;
      logic [PERIOD_W-1:0] samples_per_envelope;
   } cfg_type;

   typedef struct packed {
      logic                bit_valid;
      logic                bit_value;
      logic [RECENT_W-1:0] recent_bits;
      logic [COUNT_W-1:0]  bit_count;
      logic [COUNT_W-1:0]  ones_seen;
      logic [COUNT_W-1:0]  match_55_count;
      logic [COUNT_W-1:0]  match_aa_count;
      logic [TOTAL_W-1:0]  envelope_total;
      logic [COUNT_W-1:0]  envelope_items;
   } result_type;

endpackage

// ===== src/aebs_if.sv =====
// ----------------------------------------------------------------------------
// aebs_if
// Valid/ready channel interfaces for request, response and CSR words.
// ----------------------------------------------------------------------------
interface aebs_req_if;
   logic                         valid;
   logic                         ready;
   logic [aebs_pkg::ENV_W-1:0]   env_sum;

   modport source (output valid, output env_sum, input ready);
   modport sink   (input valid, input env_sum, output ready);
endinterface

interface aebs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           bit_valid;
   logic                           bit_value;
   logic [aebs_pkg::RECENT_W-1:0]  recent_bits;
   logic [aebs_pkg::COUNT_W-1:0]   bit_count;
   logic [aebs_pkg::COUNT_W-1:0]   ones_seen;
   logic [aebs_pkg::COUNT_W-1:0]   match_55_count;
   logic [aebs_pkg::COUNT_W-1:0]   match_aa_count;
   logic [aebs_pkg::TOTAL_W-1:0]   envelope_total;
   logic [aebs_pkg::COUNT_W-1:0]   envelope_items;

   modport source (output valid, output bit_valid, output bit_value, output recent_bits,
                   output bit_count, output ones_seen, output match_55_count,
                   output match_aa_count, output envelope_total, output envelope_items,
                   input ready);
   modport sink   (input valid, input bit_valid, input bit_value, input recent_bits,
                   input bit_count, input ones_seen, input match_55_count,
                   input match_aa_count, input envelope_total, input envelope_items,
                   output ready);
endinterface

interface aebs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [aebs_pkg::CSR_INDEX_W-1:0]  index;
   logic [aebs_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/aebs_core.sv =====
// ----------------------------------------------------------------------------
// aebs_core
// Slicer state: phase accumulator, vote counters, bit history, statistics.
// ----------------------------------------------------------------------------
module aebs_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [aebs_pkg::ENV_W-1:0]   env_sum,
   input  aebs_pkg::cfg_type            cfg,
   output aebs_pkg::result_type         result
);

   logic [aebs_pkg::PHASE_W-1:0]       phase_ff, phase_in;
   logic [aebs_pkg::VOTE_W-1:0]        votes_one_ff, votes_one_in;
   logic [aebs_pkg::VOTE_W-1:0]        votes_cast_ff, votes_cast_in;
   logic [aebs_pkg::HISTORY_BITS-1:0]  history_ff, history_in;
   logic [aebs_pkg::COUNT_W-1:0]       bits_ff, bits_in;
   logic [aebs_pkg::COUNT_W-1:0]       ones_ff, ones_in;
   logic [aebs_pkg::COUNT_W-1:0]       hits_55_ff, hits_55_in;
   logic [aebs_pkg::COUNT_W-1:0]       hits_aa_ff, hits_aa_in;
   logic [aebs_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic [aebs_pkg::COUNT_W-1:0]       items_ff, items_in;

   logic [aebs_pkg::PERIOD_W-1:0]      spb, spe_raw, spe;
   logic [aebs_pkg::VOTE_W-1:0]        votes_one_nx, votes_cast_nx;
   logic [aebs_pkg::PHASE_W-1:0]       phase_sum, phase_sub;
   logic                               decide, bit_dec;
   logic [aebs_pkg::HISTORY_BITS-1:0]  history_sh;
   logic [7:0]                         low_byte;

   always_comb begin
      spb     = (cfg.samples_per_bit == '0) ? aebs_pkg::PERIOD_W'(1)
                                            : cfg.samples_per_bit;
      spe_raw = (cfg.samples_per_envelope == '0) ? aebs_pkg::PERIOD_W'(1)
                                                 : cfg.samples_per_envelope;
      spe     = (spe_raw > spb) ? spb : spe_raw;

      votes_cast_nx = (votes_cast_ff != aebs_pkg::VOTE_MAX) ? votes_cast_ff + 1'b1
                                                              : votes_cast_ff;
      votes_one_nx  = (env_sum > cfg.vote_threshold &&
                       votes_one_ff != aebs_pkg::VOTE_MAX) ? votes_one_ff + 1'b1
                                                             : votes_one_ff;

      phase_sum = phase_ff + {1'b0, spe};
      decide    = phase_sum >= {1'b0, spb};
      phase_sub = phase_sum - {1'b0, spb};

      // tie goes to one
      bit_dec    = {votes_one_nx, 1'b0} >= {1'b0, votes_cast_nx};
      history_sh = {history_ff[aebs_pkg::HISTORY_BITS-2:0], bit_dec};
      low_byte   = history_sh[7:0];

      total_in = total_ff + aebs_pkg::TOTAL_W'(env_sum);
      items_in = items_ff + 1'b1;

      if (decide) begin
         phase_in      = (phase_sub >= {1'b0, spb}) ? '0 : phase_sub;
         votes_one_in  = '0;
         votes_cast_in = '0;
         history_in    = history_sh;
         bits_in       = bits_ff + 1'b1;
         ones_in       = bit_dec ? ones_ff + 1'b1 : ones_ff;
         hits_55_in    = (low_byte == aebs_pkg::PATTERN_55) ? hits_55_ff + 1'b1 : hits_55_ff;
         hits_aa_in    = (low_byte == aebs_pkg::PATTERN_AA) ? hits_aa_ff + 1'b1 : hits_aa_ff;
      end else begin
         phase_in      = phase_sum;
         votes_one_in  = votes_one_nx;
         votes_cast_in = votes_cast_nx;
         history_in    = history_ff;
         bits_in       = bits_ff;
         ones_in       = ones_ff;
         hits_55_in    = hits_55_ff;
         hits_aa_in    = hits_aa_ff;
      end

      result.bit_valid      = decide;
      result.bit_value      = decide & bit_dec;
      result.recent_bits    = aebs_pkg::RECENT_W'(history_in);
      result.bit_count      = bits_in;
      result.ones_seen      = ones_in;
      result.match_55_count = hits_55_in;
      result.match_aa_count = hits_aa_in;
      result.envelope_total = total_in;
      result.envelope_items = items_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         votes_one_ff  <= '0;
         votes_cast_ff <= '0;
         history_ff    <= '0;
         bits_ff       <= '0;
         ones_ff       <= '0;
         hits_55_ff    <= '0;
         hits_aa_ff    <= '0;
         total_ff      <= '0;
         items_ff      <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         votes_one_ff  <= votes_one_in;
         votes_cast_ff <= votes_cast_in;
         history_ff    <= history_in;
         bits_ff       <= bits_in;
         ones_ff       <= ones_in;
         hits_55_ff    <= hits_55_in;
         hits_aa_ff    <= hits_aa_in;
         total_ff      <= total_in;
         items_ff      <= items_in;
      end
   end

endmodule

// ===== src/ask_envelope_bit_slicer_top.sv =====
// ----------------------------------------------------------------------------
// ask_envelope_bit_slicer_top
// ASK envelope bit slicer with majority vote and pattern statistics.
// ----------------------------------------------------------------------------
// Takes one envelope sum word per clock while rsp.ready holds, and returns
// exactly one result word per request, in order. A request word is
// registered in the input register, then sliced against the live state and
// written to the response register; a stall on rsp.ready can hold it in the
// input register. The response register and the input register let a new
// request be taken while a result waits on rsp.ready.
// CSR writes are always accepted and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module ask_envelope_bit_slicer_top (
   input  logic    clock,
   input  logic    reset,
   aebs_req_if.sink   req,
   aebs_rsp_if.source rsp,
   aebs_csr_if.sink   csr
);

   aebs_pkg::cfg_type              cfg_ff;
   logic                           in_valid_ff;
   logic [aebs_pkg::ENV_W-1:0]     in_env_ff;
   logic                           out_valid_ff;
   aebs_pkg::result_type           out_ff;
   aebs_pkg::result_type           result;
   logic                           advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || !out_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vote_threshold       <= aebs_pkg::THRESHOLD_RESET;
         cfg_ff.samples_per_bit      <= aebs_pkg::SPB_RESET;
         cfg_ff.samples_per_envelope <= aebs_pkg::SPE_RESET;
      end else if (csr.valid) begin
         case (aebs_pkg::csr_index_type'(csr.index))
            aebs_pkg::CSR_VOTE_THRESHOLD:
               cfg_ff.vote_threshold <= aebs_pkg::ENV_W'(csr.data);
            aebs_pkg::CSR_SAMPLES_PER_BIT:
               cfg_ff.samples_per_bit <= aebs_pkg::PERIOD_W'(csr.data);
            aebs_pkg::CSR_SAMPLES_PER_ENVELOPE:
               cfg_ff.samples_per_envelope <= aebs_pkg::PERIOD_W'(csr.data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_env_ff <= req.env_sum;
      end
   end

   aebs_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .env_sum      (in_env_ff),
      .cfg          (cfg_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp.ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.bit_valid      = out_ff.bit_valid;
   assign rsp.bit_value      = out_ff.bit_value;
   assign rsp.recent_bits    = out_ff.recent_bits;
   assign rsp.bit_count      = out_ff.bit_count;
   assign rsp.ones_seen      = out_ff.ones_seen;
   assign rsp.match_55_count = out_ff.match_55_count;
   assign rsp.match_aa_count = out_ff.match_aa_count;
   assign rsp.envelope_total = out_ff.envelope_total;
   assign rsp.envelope_items = out_ff.envelope_items;

endmodule

// ===== src/aebs_checker.sv =====
// ----------------------------------------------------------------------------
// aebs_checker
// Port-level assertions for the bit slicer, bound to the top level.
// ----------------------------------------------------------------------------
module aebs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_bit_valid,
   input  logic                          rsp_bit_value,
   input  logic [aebs_pkg::RECENT_W-1:0] rsp_recent_bits,
   input  logic [aebs_pkg::COUNT_W-1:0]  rsp_envelope_items
);

   logic                          seen_ff;
   logic [aebs_pkg::COUNT_W-1:0]  last_items_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         last_items_ff <= rsp_envelope_items;
      end
   end

   // each response word accounts for exactly one request word
   a_items_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff |-> rsp_envelope_items == last_items_ff + 1'b1)
      else $error("envelope_items did not advance by one");

   a_bit_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bit_valid |-> !rsp_bit_value)
      else $error("bit_value set without bit_valid");

   a_history_newest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_valid |-> rsp_recent_bits[0] == rsp_bit_value)
      else $error("newest history bit differs from decided bit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_envelope_items))
      else $error("stalled response word changed");

endmodule

bind ask_envelope_bit_slicer_top aebs_checker u_aebs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_bit_valid      (rsp.bit_valid),
   .rsp_bit_value      (rsp.bit_value),
   .rsp_recent_bits    (rsp.recent_bits),
   .rsp_envelope_items (rsp.envelope_items)
);

// ===== dv/tb_ask_envelope_bit_slicer_top.sv =====
// ----------------------------------------------------------------------------
// tb_ask_envelope_bit_slicer_top
// Self-checking bench for the ASK envelope bit slicer.
// ----------------------------------------------------------------------------
// Envelope words go in on the request channel and every response word is
// compared field by field with an in-bench slicer model fed the same words.
// A short table of directed words and CSR writes covers field extremes, zero
// and clamped periods, vote ties, the 0x55/0xAA history patterns and a bit
// period lowered mid-bit. Random phases follow, each with fresh CSR settings
// and bit-shaped envelope streams plus noise, one phase that drives the vote
// counters to their cap, and one long response hold-off. Both sides idle in
// random bursts except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_ask_envelope_bit_slicer_top;

   localparam logic [aebs_pkg::ENV_W-1:0] ENV_MAX = '1;
   localparam int ENVELOPE_TARGET = 1750;
   localparam int CALM_AFTER      = 1500;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic                          is_write;
      aebs_pkg::csr_index_type       reg_index;
      logic [aebs_pkg::ENV_W-1:0]    value;
      logic                          fixed;
      logic                          fixed_valid;
      logic                          fixed_bit;
      logic [aebs_pkg::RECENT_W-1:0] fixed_recent;
   } plan_row_type;

   logic clock;
   logic reset;

   aebs_req_if req_bus ();
   aebs_rsp_if rsp_bus ();
   aebs_csr_if csr_bus ();

   ask_envelope_bit_slicer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // slicer model state
   logic [aebs_pkg::ENV_W-1:0]    model_threshold;
   logic [aebs_pkg::PERIOD_W-1:0] model_spb;
   logic [aebs_pkg::PERIOD_W-1:0] model_spe;
   logic [aebs_pkg::PHASE_W-1:0]  model_phase;
   logic [aebs_pkg::VOTE_W-1:0]   model_votes_one;
   logic [aebs_pkg::VOTE_W-1:0]   model_votes_cast;
   logic [aebs_pkg::RECENT_W-1:0] model_history;
   logic [aebs_pkg::COUNT_W-1:0]  model_bits;
   logic [aebs_pkg::COUNT_W-1:0]  model_ones;
   logic [aebs_pkg::COUNT_W-1:0]  model_hits_55;
   logic [aebs_pkg::COUNT_W-1:0]  model_hits_aa;
   logic [aebs_pkg::TOTAL_W-1:0]  model_total;
   logic [aebs_pkg::COUNT_W-1:0]  model_items;

   aebs_pkg::result_type slices_due[$];
   plan_row_type         directed_plan[39];
   int unsigned cycle_count = 0;
   int          failures = 0;
   int          envelopes_sent;
   int          sender_gap_pct;
   int          reply_stall_pct;
   int          hold_left;
   int          stall_left;
   bit          hold_request;
   bit          hold_started;
   bit          calm_tail;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ask_envelope_bit_slicer_top: FAIL");
         $finish;
      end
   end

   function automatic plan_row_type env_row(input logic [aebs_pkg::ENV_W-1:0] sum);
      plan_row_type r;
      r = '0;
      r.value = sum;
      return r;
   endfunction

   function automatic plan_row_type env_fixed(input logic [aebs_pkg::ENV_W-1:0] sum,
                                              input logic v, input logic b,
                                              input logic [aebs_pkg::RECENT_W-1:0] recent);
      plan_row_type r;
      r = '0;
      r.value = sum;
      r.fixed = 1'b1;
      r.fixed_valid = v;
      r.fixed_bit = b;
      r.fixed_recent = recent;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input aebs_pkg::csr_index_type idx,
                                            input logic [aebs_pkg::ENV_W-1:0] value);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.reg_index = idx;
      r.value = value;
      return r;
   endfunction

   function automatic aebs_pkg::result_type slice_envelope(
         input logic [aebs_pkg::ENV_W-1:0] sum);
      aebs_pkg::result_type r;
      logic [aebs_pkg::PHASE_W-1:0] spb;
      logic [aebs_pkg::PHASE_W-1:0] spe;
      logic decided;
      r = '0;
      spb = (model_spb == '0) ? aebs_pkg::PHASE_W'(1) : {1'b0, model_spb};
      spe = (model_spe == '0) ? aebs_pkg::PHASE_W'(1) : {1'b0, model_spe};
      if (spe > spb) spe = spb;
      model_total = model_total + aebs_pkg::TOTAL_W'(sum);
      model_items = model_items + 1'b1;
      if (model_votes_cast != aebs_pkg::VOTE_MAX) model_votes_cast = model_votes_cast + 1'b1;
      if (sum > model_threshold && model_votes_one != aebs_pkg::VOTE_MAX) begin
         model_votes_one = model_votes_one + 1'b1;
      end
      model_phase = model_phase + spe;
      if (model_phase >= spb) begin
         model_phase = model_phase - spb;
         // bit period lowered mid-bit
         if (model_phase >= spb) model_phase = '0;
         // tie decides one
         decided = ({1'b0, model_votes_one, 1'b0} >= {2'b00, model_votes_cast});
         r.bit_valid = 1'b1;
         r.bit_value = decided;
         model_bits = model_bits + 1'b1;
         if (decided) model_ones = model_ones + 1'b1;
         model_history = {model_history[aebs_pkg::RECENT_W-2:0], decided};
         if (model_history[7:0] == aebs_pkg::PATTERN_55) model_hits_55 = model_hits_55 + 1'b1;
         if (model_history[7:0] == aebs_pkg::PATTERN_AA) model_hits_aa = model_hits_aa + 1'b1;
         model_votes_one = '0;
         model_votes_cast = '0;
      end
      r.recent_bits = model_history;
      r.bit_count = model_bits;
      r.ones_seen = model_ones;
      r.match_55_count = model_hits_55;
      r.match_aa_count = model_hits_aa;
      r.envelope_total = model_total;
      r.envelope_items = model_items;
      return r;
   endfunction

   function void match_field(input string name, input logic [aebs_pkg::TOTAL_W-1:0] want,
                             input logic [aebs_pkg::TOTAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   task automatic send_envelope(input logic [aebs_pkg::ENV_W-1:0] sum, input logic fixed,
                                input logic fv, input logic fb,
                                input logic [aebs_pkg::RECENT_W-1:0] fr);
      aebs_pkg::result_type predicted;
      int gap;
      if (!calm_tail && $urandom_range(0, 99) < sender_gap_pct) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.env_sum <= sum;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = slice_envelope(sum);
      if (fixed) begin
         predicted.bit_valid = fv;
         predicted.bit_value = fb;
         predicted.recent_bits = fr;
      end
      slices_due.push_back(predicted);
      envelopes_sent++;
   endtask

   task automatic write_register(input aebs_pkg::csr_index_type idx,
                                 input logic [aebs_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         aebs_pkg::CSR_VOTE_THRESHOLD:       model_threshold = value[aebs_pkg::ENV_W-1:0];
         aebs_pkg::CSR_SAMPLES_PER_BIT:      model_spb = value[aebs_pkg::PERIOD_W-1:0];
         aebs_pkg::CSR_SAMPLES_PER_ENVELOPE: model_spe = value[aebs_pkg::PERIOD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (slices_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response side: random stall bursts plus the long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      hold_left = 0;
      stall_left = 0;
      hold_started = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_started) begin
            hold_left = HOLD_CYCLES;
            hold_started = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 99) < reply_stall_pct) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      aebs_pkg::result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (slices_due.size() == 0) begin
            $error("response word with no result due");
            failures++;
         end else begin
            due = slices_due.pop_front();
            match_field("bit_valid", aebs_pkg::TOTAL_W'(due.bit_valid),
                        aebs_pkg::TOTAL_W'(rsp_bus.bit_valid));
            match_field("bit_value", aebs_pkg::TOTAL_W'(due.bit_value),
                        aebs_pkg::TOTAL_W'(rsp_bus.bit_value));
            match_field("recent_bits", aebs_pkg::TOTAL_W'(due.recent_bits),
                        aebs_pkg::TOTAL_W'(rsp_bus.recent_bits));
            match_field("bit_count", aebs_pkg::TOTAL_W'(due.bit_count),
                        aebs_pkg::TOTAL_W'(rsp_bus.bit_count));
            match_field("ones_seen", aebs_pkg::TOTAL_W'(due.ones_seen),
                        aebs_pkg::TOTAL_W'(rsp_bus.ones_seen));
            match_field("match_55_count", aebs_pkg::TOTAL_W'(due.match_55_count),
                        aebs_pkg::TOTAL_W'(rsp_bus.match_55_count));
            match_field("match_aa_count", aebs_pkg::TOTAL_W'(due.match_aa_count),
                        aebs_pkg::TOTAL_W'(rsp_bus.match_aa_count));
            match_field("envelope_total", due.envelope_total, rsp_bus.envelope_total);
            match_field("envelope_items", aebs_pkg::TOTAL_W'(due.envelope_items),
                        aebs_pkg::TOTAL_W'(rsp_bus.envelope_items));
         end
      end
   end

   initial begin
      int phase_index;
      int spb_eff;
      int spe_eff;
      int per_bit;
      int left_in_bit;
      int pattern_kind;
      int thr;
      logic symbol;
      logic [aebs_pkg::ENV_W-1:0] env;
      logic [aebs_pkg::CSR_DATA_W-1:0] word;
      logic [aebs_pkg::PERIOD_W-1:0] period;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.env_sum = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = aebs_pkg::CSR_VOTE_THRESHOLD;
      csr_bus.data = '0;
      envelopes_sent = 0;
      sender_gap_pct = 10;
      reply_stall_pct = 10;
      hold_request = 1'b0;
      calm_tail = 1'b0;

      model_threshold = aebs_pkg::THRESHOLD_RESET;
      model_spb = aebs_pkg::SPB_RESET;
      model_spe = aebs_pkg::SPE_RESET;
      model_phase = '0;
      model_votes_one = '0;
      model_votes_cast = '0;
      model_history = '0;
      model_bits = '0;
      model_ones = '0;
      model_hits_55 = '0;
      model_hits_aa = '0;
      model_total = '0;
      model_items = '0;

      directed_plan = '{
         env_fixed(0, 1'b0, 1'b0, 16'h0000),
         env_fixed(ENV_MAX, 1'b0, 1'b0, 16'h0000),
         env_fixed(6000, 1'b0, 1'b0, 16'h0000),
         env_fixed(6001, 1'b0, 1'b0, 16'h0000),
         env_row(0),
         csr_row(aebs_pkg::CSR_VOTE_THRESHOLD, 0),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 1),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 1),
         env_fixed(0, 1'b1, 1'b0, 16'h0000),
         env_fixed(1, 1'b1, 1'b1, 16'h0001),
         env_fixed(0, 1'b1, 1'b0, 16'h0002),
         env_fixed(ENV_MAX, 1'b1, 1'b1, 16'h0005),
         env_fixed(0, 1'b1, 1'b0, 16'h000A),
         env_fixed(1, 1'b1, 1'b1, 16'h0015),
         env_fixed(0, 1'b1, 1'b0, 16'h002A),
         env_fixed(1, 1'b1, 1'b1, 16'h0055),
         env_fixed(0, 1'b1, 1'b0, 16'h00AA),
         csr_row(aebs_pkg::CSR_VOTE_THRESHOLD, ENV_MAX),
         env_fixed(ENV_MAX, 1'b1, 1'b0, 16'h0154),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 0),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 0),
         env_fixed(5, 1'b1, 1'b0, 16'h02A8),
         csr_row(aebs_pkg::CSR_VOTE_THRESHOLD, 100),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 2),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 1023),
         env_fixed(200, 1'b1, 1'b1, 16'h0551),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 1),
         env_fixed(200, 1'b0, 1'b0, 16'h0551),
         env_fixed(50, 1'b1, 1'b1, 16'h0AA3),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 1000),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 900),
         env_row(7),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 10),
         env_row(7),
         env_row(300),
         csr_row(aebs_pkg::CSR_UNUSED, 18'h2AAAA),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_BIT, 18'h3FCB4),
         csr_row(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 18'h3FC28),
         csr_row(aebs_pkg::CSR_VOTE_THRESHOLD, 6000)
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         if (directed_plan[r].is_write) begin
            wait_idle();
            write_register(directed_plan[r].reg_index, directed_plan[r].value);
         end else begin
            send_envelope(directed_plan[r].value, directed_plan[r].fixed,
                          directed_plan[r].fixed_valid, directed_plan[r].fixed_bit,
                          directed_plan[r].fixed_recent);
         end
      end

      phase_index = 0;
      while (envelopes_sent < ENVELOPE_TARGET) begin
         wait_idle();
         if (envelopes_sent >= CALM_AFTER) calm_tail = 1'b1;
         case ($urandom_range(0, 3))
            0: sender_gap_pct = 0;
            1: sender_gap_pct = 5;
            2: sender_gap_pct = 15;
            default: sender_gap_pct = 40;
         endcase
         case ($urandom_range(0, 3))
            0: reply_stall_pct = 0;
            1: reply_stall_pct = 5;
            2: reply_stall_pct = 15;
            default: reply_stall_pct = 40;
         endcase

         if (phase_index == 4) begin
            // flush phase and votes, then a full 1023-word bit, all votes for one
            write_register(aebs_pkg::CSR_SAMPLES_PER_BIT, 1);
            write_register(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, 1);
            send_envelope(aebs_pkg::ENV_W'($urandom), 1'b0, 1'b0, 1'b0, 16'h0000);
            wait_idle();
            write_register(aebs_pkg::CSR_VOTE_THRESHOLD, 0);
            write_register(aebs_pkg::CSR_SAMPLES_PER_BIT, {8'h00, aebs_pkg::VOTE_MAX});
            repeat (int'(aebs_pkg::VOTE_MAX) + 7) begin
               send_envelope(aebs_pkg::ENV_W'($urandom_range(1, ENV_MAX)),
                             1'b0, 1'b0, 1'b0, 16'h0000);
            end
         end else begin
            case ($urandom_range(0, 3))
               0: word = '0;
               1: word = ENV_MAX;
               default: word = aebs_pkg::CSR_DATA_W'($urandom_range(1000, 200000));
            endcase
            write_register(aebs_pkg::CSR_VOTE_THRESHOLD, word);

            case ($urandom_range(0, 9))
               0: period = '0;
               1: period = 1;
               2: period = '1;
               3, 4, 5, 6: period = aebs_pkg::PERIOD_W'($urandom_range(1, 8));
               default: period = aebs_pkg::PERIOD_W'($urandom_range(1, 1023));
            endcase
            word = {8'h00, period};
            if ($urandom_range(0, 3) == 0) begin
               word[aebs_pkg::CSR_DATA_W-1:aebs_pkg::PERIOD_W] =
                  (aebs_pkg::CSR_DATA_W - aebs_pkg::PERIOD_W)'($urandom);
            end
            write_register(aebs_pkg::CSR_SAMPLES_PER_BIT, word);

            spb_eff = (model_spb == '0) ? 1 : int'(model_spb);
            case ($urandom_range(0, 5))
               0: period = '0;
               1: period = '1;
               2: period = aebs_pkg::PERIOD_W'(spb_eff);
               default: period = aebs_pkg::PERIOD_W'($urandom_range(1, spb_eff));
            endcase
            word = {8'h00, period};
            if ($urandom_range(0, 3) == 0) begin
               word[aebs_pkg::CSR_DATA_W-1:aebs_pkg::PERIOD_W] =
                  (aebs_pkg::CSR_DATA_W - aebs_pkg::PERIOD_W)'($urandom);
            end
            write_register(aebs_pkg::CSR_SAMPLES_PER_ENVELOPE, word);

            spe_eff = (model_spe == '0) ? 1 : int'(model_spe);
            if (spe_eff > spb_eff) spe_eff = spb_eff;
            per_bit = (spb_eff + spe_eff - 1) / spe_eff;
            pattern_kind = $urandom_range(0, 2);
            symbol = 1'($urandom);
            left_in_bit = per_bit;
            if (phase_index == 1) hold_request = 1'b1;

            repeat ($urandom_range(16, 64)) begin
               if (left_in_bit == 0) begin
                  left_in_bit = per_bit;
                  case (pattern_kind)
                     0: symbol = ~symbol;
                     1: symbol = 1'($urandom);
                     default: ;
                  endcase
               end
               left_in_bit--;
               thr = int'(model_threshold);
               case ($urandom_range(0, 15))
                  0: env = aebs_pkg::ENV_W'($urandom);
                  1: env = symbol ? ENV_MAX : '0;
                  2: env = aebs_pkg::ENV_W'((symbol && thr < ENV_MAX) ? thr + 1 : thr);
                  default: begin
                     if (symbol && thr < ENV_MAX) begin
                        env = aebs_pkg::ENV_W'(thr + $urandom_range(1, ENV_MAX - thr));
                     end else begin
                        env = aebs_pkg::ENV_W'($urandom_range(0, thr));
                     end
                  end
               endcase
               send_envelope(env, 1'b0, 1'b0, 1'b0, 16'h0000);
            end
         end
         phase_index++;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("tb_ask_envelope_bit_slicer_top: PASS");
      end else begin
         $display("tb_ask_envelope_bit_slicer_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== ask_envelope_bit_slicer_top.f =====
src/aebs_pkg.sv
src/aebs_if.sv
src/aebs_core.sv
src/ask_envelope_bit_slicer_top.sv
src/aebs_checker.sv
dv/tb_ask_envelope_bit_slicer_top.sv
